// File: rtl/encoder_speed_meter_core_assert.svh
// ----------------------------------------------------------------------------
// Encoder speed meter assertion macros
// Shared property forms for the checks at the end of the core.
// ----------------------------------------------------------------------------
`ifndef ENCODER_SPEED_METER_CORE_ASSERT_SVH
`define ENCODER_SPEED_METER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ESM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ESM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/esm_pkg.sv
// ----------------------------------------------------------------------------
// Encoder speed meter package
// Widths, register indexes, reset values and helper functions of the core.
// ----------------------------------------------------------------------------
package esm_pkg;

    localparam int unsigned TIME_W  = 16;
    localparam int unsigned POT_W   = 10;
    localparam int unsigned BARS_W  = 4;
    localparam int unsigned LEDS_W  = 8;
    localparam int unsigned SPEED_W = 24;
    localparam int unsigned CFG_W   = 24;
    localparam int unsigned CIDX_W  = 2;

    // Dividend of the shared divider: wide enough for pot_sample * PWM full scale.
    localparam int unsigned DIV_BITS  = POT_W + TIME_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_BITS);
    // Seven times the distance of the period above the low threshold fits here.
    localparam int unsigned SCALED_W  = TIME_W + 3;

    typedef logic [TIME_W-1:0]  t_time;
    typedef logic [POT_W-1:0]   t_pot;
    typedef logic [BARS_W-1:0]  t_bars;
    typedef logic [LEDS_W-1:0]  t_leds;
    typedef logic [SPEED_W-1:0] t_speed;
    typedef logic [CFG_W-1:0]   t_cfg_data;
    typedef logic [CIDX_W-1:0]  t_cfg_index;
    typedef logic [DIV_BITS-1:0] t_dvd;

    // What the shared divider is currently computing.
    typedef logic [1:0] t_phase;
    localparam t_phase PH_BARS  = 2'd0;
    localparam t_phase PH_DUTY  = 2'd1;
    localparam t_phase PH_SPEED = 2'd2;

    localparam t_cfg_index CFG_LOW_THRESH  = 2'd0;
    localparam t_cfg_index CFG_MAX_PERIOD  = 2'd1;
    localparam t_cfg_index CFG_SPEED_NUM   = 2'd2;
    localparam t_cfg_index CFG_PWM_FULL    = 2'd3;

    localparam t_time  RST_LOW_THRESH = 16'd200;
    localparam t_time  RST_MAX_PERIOD = 16'd3000;
    localparam t_speed RST_SPEED_NUM  = 24'd49656;
    localparam t_time  RST_PWM_FULL   = 16'd24999;

    localparam t_time POT_FULL  = 16'd1023;
    localparam t_bars BARS_MIN  = 4'd1;
    localparam t_bars BARS_MAX  = 4'd8;

    // Thermometer code: bit i is set when the count exceeds i.
    function automatic t_leds bar_leds_of(input t_bars count);
        t_leds leds;
        leds = '0;
        for (int i = 0; i < LEDS_W; i++) begin
            leds[i] = (count > t_bars'(i));
        end
        return leds;
    endfunction

endpackage

// File: rtl/encoder_speed_meter_core.sv
// ----------------------------------------------------------------------------
// Encoder speed meter core
// Encoder period tachometer with bar graph, speed quotient and PWM duty.
// ----------------------------------------------------------------------------
// One word is taken at a time; o_in_stall stays high from acceptance until its
// result is loaded into the output register. All division runs through a single
// restoring divider that retires one quotient bit per cycle. An edge word whose
// period lies between the thresholds takes one divider pass, and a clamped one
// none; a tick word with a nonzero period takes a multiply step and two divider
// passes (duty, then speed), and with a zero period only the multiply and the duty
// pass. The result waits in the done state only while the previous result is
// still stalled in the output register.
module encoder_speed_meter_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Configuration write port
    input  logic                    i_cfg_we,
    input  esm_pkg::t_cfg_index     i_cfg_index,
    input  esm_pkg::t_cfg_data      i_cfg_data,
    // Input channel
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_opcode,
    input  esm_pkg::t_time          i_capture_time,
    input  esm_pkg::t_pot           i_pot_sample,
    // Output channel
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_kind,
    output esm_pkg::t_time          o_period,
    output esm_pkg::t_bars          o_bar_count,
    output esm_pkg::t_leds          o_bar_leds,
    output esm_pkg::t_speed         o_speed,
    output logic                    o_speed_valid,
    output esm_pkg::t_time          o_duty
);

    import esm_pkg::*;

    `include "encoder_speed_meter_core_assert.svh"

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EDGE = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_POST = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    // Configuration registers
    t_time  r_low_thresh;
    t_time  r_max_period;
    t_speed r_speed_num;
    t_time  r_pwm_full;

    // Block state
    t_time  r_last_time;
    t_time  r_period;

    // Sequencer and working registers
    logic [2:0]           r_state;
    t_phase               r_phase;
    logic                 r_kind;
    t_pot                 r_pot;
    t_bars                r_bars;
    t_speed               r_speed;
    logic                 r_speed_valid;
    t_time                r_duty;

    // Shared divider: r_dvd shifts the dividend out and the quotient in.
    t_dvd                 r_dvd;
    t_time                r_divisor;
    t_time                r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;

    // Output register
    logic                 r_out_valid;
    logic                 r_o_kind;
    t_time                r_o_period;
    t_bars                r_o_bars;
    t_leds                r_o_leds;
    t_speed               r_o_speed;
    logic                 r_o_speed_valid;
    t_time                r_o_duty;

    logic                 in_accept;
    logic                 out_accept;
    logic                 out_free;
    logic                 out_load;
    logic [TIME_W:0]      div_trial;
    logic                 div_qbit;
    t_time                span_lo;
    logic [SCALED_W-1:0]  scaled;

    logic                 div_busy;
    logic                 out_edge;
    logic                 edge_bars_ok;
    logic                 out_spd;
    logic                 spd_src_ok;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_accept = r_out_valid && !i_out_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign out_load   = (r_state == S_DONE) && out_free;
    assign o_in_stall = (r_state != S_IDLE);

    assign div_trial = {r_rem, r_dvd[DIV_BITS-1]};
    assign div_qbit  = (div_trial >= {1'b0, r_divisor});

    // Seven times the distance above the low threshold, by shift and subtract.
    assign span_lo = r_period - r_low_thresh;
    assign scaled  = {span_lo, 3'b000} - {3'b000, span_lo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_thresh <= RST_LOW_THRESH;
            r_max_period <= RST_MAX_PERIOD;
            r_speed_num  <= RST_SPEED_NUM;
            r_pwm_full   <= RST_PWM_FULL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LOW_THRESH: r_low_thresh <= i_cfg_data[TIME_W-1:0];
                CFG_MAX_PERIOD: r_max_period <= i_cfg_data[TIME_W-1:0];
                CFG_SPEED_NUM:  r_speed_num  <= i_cfg_data[SPEED_W-1:0];
                CFG_PWM_FULL:   r_pwm_full   <= i_cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last_time <= '0;
            r_period    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= out_load || (r_out_valid && !out_accept);
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_kind        <= i_opcode;
                        r_pot         <= i_pot_sample;
                        r_bars        <= '0;
                        r_speed       <= '0;
                        r_speed_valid <= 1'b0;
                        r_duty        <= '0;
                        if (!i_opcode) begin
                            r_period    <= i_capture_time - r_last_time;
                            r_last_time <= i_capture_time;
                            r_state     <= S_EDGE;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_EDGE: begin
                    if (r_period <= r_low_thresh) begin
                        r_bars  <= BARS_MIN;
                        r_state <= S_DONE;
                    end else if (r_period >= r_max_period) begin
                        r_bars  <= BARS_MAX;
                        r_state <= S_DONE;
                    end else begin
                        r_dvd     <= DIV_BITS'(scaled);
                        r_divisor <= r_max_period - r_low_thresh;
                        r_rem     <= '0;
                        r_cnt     <= DIV_CNT_W'(DIV_BITS - 1);
                        r_phase   <= PH_BARS;
                        r_state   <= S_DIV;
                    end
                end
                S_MUL: begin
                    // The product lands straight in the divider's dividend.
                    r_dvd     <= t_dvd'(r_pot) * t_dvd'(r_pwm_full);
                    r_divisor <= POT_FULL;
                    r_rem     <= '0;
                    r_cnt     <= DIV_CNT_W'(DIV_BITS - 1);
                    r_phase   <= PH_DUTY;
                    r_state   <= S_DIV;
                end
                S_DIV: begin
                    if (div_qbit) begin
                        r_rem <= TIME_W'(div_trial - {1'b0, r_divisor});
                    end else begin
                        r_rem <= div_trial[TIME_W-1:0];
                    end
                    r_dvd <= {r_dvd[DIV_BITS-2:0], div_qbit};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_POST;
                    end
                end
                S_POST: begin
                    case (r_phase)
                        PH_BARS: begin
                            r_bars  <= BARS_MIN + r_dvd[BARS_W-1:0];
                            r_state <= S_DONE;
                        end
                        PH_DUTY: begin
                            if (r_dvd > t_dvd'(r_pwm_full)) begin
                                r_duty <= r_pwm_full;
                            end else begin
                                r_duty <= r_dvd[TIME_W-1:0];
                            end
                            if (r_period != '0) begin
                                r_dvd     <= t_dvd'(r_speed_num);
                                r_divisor <= r_period;
                                r_rem     <= '0;
                                r_cnt     <= DIV_CNT_W'(DIV_BITS - 1);
                                r_phase   <= PH_SPEED;
                                r_state   <= S_DIV;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        PH_SPEED: begin
                            r_speed       <= r_dvd[SPEED_W-1:0];
                            r_speed_valid <= 1'b1;
                            r_state       <= S_DONE;
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_DONE: begin
                    if (out_free) begin
                        r_o_kind        <= r_kind;
                        r_o_period      <= r_period;
                        r_o_bars        <= r_bars;
                        r_o_leds        <= bar_leds_of(r_bars);
                        r_o_speed       <= r_speed;
                        r_o_speed_valid <= r_speed_valid;
                        r_o_duty        <= r_duty;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_o_kind;
    assign o_period      = r_o_period;
    assign o_bar_count   = r_o_bars;
    assign o_bar_leds    = r_o_leds;
    assign o_speed       = r_o_speed;
    assign o_speed_valid = r_o_speed_valid;
    assign o_duty        = r_o_duty;

    assign div_busy     = (r_state == S_DIV);
    assign out_edge     = r_out_valid && !r_o_kind;
    assign edge_bars_ok = (r_o_bars >= BARS_MIN) && (r_o_bars <= BARS_MAX) &&
                          (r_o_leds == bar_leds_of(r_o_bars));
    assign out_spd      = r_out_valid && r_o_speed_valid;
    assign spd_src_ok   = r_o_kind && (r_o_period != '0);

    // The partial remainder always stays below the divisor.
    `ESM_ASSERT_SAME(a_div_rem, i_clk, i_rst_n, div_busy, r_rem < r_divisor, "remainder too big")

    // An accepted word always takes the sequencer out of idle.
    `ESM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_accept, o_in_stall, "still idle")

    // An edge result carries a legal bar count with its matching thermometer code.
    `ESM_ASSERT_SAME(a_edge_bars, i_clk, i_rst_n, out_edge, edge_bars_ok, "bad edge bar graph")

    // A valid speed only comes from a tick with a nonzero period.
    `ESM_ASSERT_SAME(a_speed_valid, i_clk, i_rst_n, out_spd, spd_src_ok, "speed without period")

endmodule
